[rtl/ddo_pkg.sv]
// Shared constants, types and helpers for the differential drive odometry block.
package ddo_pkg;

    // CORDIC iterations
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);

    // serial multiplier sizing
    localparam int MUL_A_W   = 65;
    localparam int MUL_B_W   = 34;
    localparam int MUL_LEN_W = 6;

    // configuration register indexes
    localparam logic [1:0] REG_LEFT_MPT  = 2'd0;
    localparam logic [1:0] REG_RIGHT_MPT = 2'd1;
    localparam logic [1:0] REG_INV_TRACK = 2'd2;

    // turns per radian, Q0.32
    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    // CORDIC start vector, Q1.30
    localparam logic signed [33:0] CORDIC_GAIN_INV_Q30 = 34'sd652032874;

    typedef struct packed {
        logic                 start;
        logic                 b_signed;
        logic [MUL_LEN_W-1:0] len;
    } mul_req_t;

    // arctangent of 2^-i in binary angle units
    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            5'd24: v = 32'sd41;
            5'd25: v = 32'sd20;
            5'd26: v = 32'sd10;
            5'd27: v = 32'sd5;
            5'd28: v = 32'sd3;
            5'd29: v = 32'sd1;
            5'd30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // round a Q.46 product to Q16.16 and add to a position with saturation
    function automatic logic [31:0] sat_add(input logic [31:0] base,
                                            input logic [MUL_A_W-1:0] p);
        logic signed [MUL_A_W-1:0] r;
        logic signed [36:0]        s;
        logic [31:0]               o;
        r = ($signed(p) + $signed(MUL_A_W'(1) << 29)) >>> 30;
        s = $signed({{5{base[31]}}, base}) + $signed(r[36:0]);
        if (s > 37'sd2147483647) begin
            o = 32'h7FFF_FFFF;
        end else if (s < -37'sd2147483648) begin
            o = 32'h8000_0000;
        end else begin
            o = s[31:0];
        end
        return o;
    endfunction

endpackage

[rtl/ddo_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ddo_serial_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ddo_pkg::mul_req_t             req,
    input  logic [ddo_pkg::MUL_A_W-1:0]   a_in,
    input  logic [ddo_pkg::MUL_B_W-1:0]   b_in,
    output logic                          done,
    output logic [ddo_pkg::MUL_A_W-1:0]   prod
);

    logic [ddo_pkg::MUL_A_W-1:0]   acc_reg, acc_next;
    logic [ddo_pkg::MUL_A_W-1:0]   a_reg;
    logic [ddo_pkg::MUL_B_W-1:0]   b_reg;
    logic [ddo_pkg::MUL_LEN_W-1:0] cnt_reg, len_reg;
    logic                          sgn_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          last;

    assign last = (cnt_reg == len_reg - ddo_pkg::MUL_LEN_W'(1));

    // add or, on a signed top bit, subtract the shifted multiplicand
    always_comb begin
        acc_next = acc_reg;
        if (b_reg[0]) begin
            if (last && sgn_reg) begin
                acc_next = acc_reg - a_reg;
            end else begin
                acc_next = acc_reg + a_reg;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + ddo_pkg::MUL_LEN_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= a_in;
            b_reg   <= b_in;
            len_reg <= req.len;
            sgn_reg <= req.b_signed;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/ddo_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);

    localparam int CW = ddo_pkg::CORDIC_CNT_W;

    logic signed [33:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [1:0]         q_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         q_start;
    logic [31:0]        r_start;
    logic signed [33:0] dx, dy;
    logic signed [31:0] at;
    logic               last;

    // reduce to the nearest quadrant
    assign q_start = 2'((angle + 32'h2000_0000) >> 30);
    assign r_start = angle - {q_start, 30'd0};

    assign dx   = y_reg >>> cnt_reg;
    assign dy   = x_reg >>> cnt_reg;
    assign at   = ddo_pkg::atan_lut(5'(cnt_reg));
    assign last = (cnt_reg == CW'(ddo_pkg::CORDIC_STEPS - 1));

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rotate toward zero residual angle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= ddo_pkg::CORDIC_GAIN_INV_Q30;
            y_reg <= '0;
            z_reg <= $signed(r_start);
            q_reg <= q_start;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    // apply the quadrant
    always_comb begin
        case (q_reg)
            2'd0: begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
            2'd1: begin
                cos_q30 = -y_reg;
                sin_q30 = x_reg;
            end
            2'd2: begin
                cos_q30 = -x_reg;
                sin_q30 = -y_reg;
            end
            default: begin
                cos_q30 = y_reg;
                sin_q30 = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

[rtl/differential_drive_odometry.sv]
// Top level of the differential drive midpoint odometry block.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata: left_tick_delta, right_tick_delta
//  m_      | out | m_tvalid / m_tready  | m_tdata: pos_x, pos_y, heading_angle
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item runs through four serial products (left, right, difference, turns),
// the CORDIC and two more serial products (x and y), then the output state.
// A new input is accepted only after the output state, so the block does not
// take a new item before it is through with the last one.
// Reset (aresetn low, synchronous) clears the pose and configuration registers to zero.
// s_tready is high only while no item is in work; a finished result waits
// in the output register and the next item may be accepted meanwhile.
module differential_drive_odometry (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] left_tick_delta, [31:16] right_tick_delta
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] heading_angle
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW = ddo_pkg::MUL_A_W;
    localparam int BW = ddo_pkg::MUL_B_W;
    localparam int LW = ddo_pkg::MUL_LEN_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DL   = 4'd1;
    localparam logic [3:0] S_DR   = 4'd2;
    localparam logic [3:0] S_RAD  = 4'd3;
    localparam logic [3:0] S_TURN = 4'd4;
    localparam logic [3:0] S_CORD = 4'd5;
    localparam logic [3:0] S_MX   = 4'd6;
    localparam logic [3:0] S_MY   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [23:0] lmpt_reg, rmpt_reg, idt_reg;
    logic [15:0] tick_r_reg;
    logic [39:0] dl_reg;
    logic [31:0] mean_reg;
    logic [31:0] dth_reg;
    logic [31:0] pose_x_reg, pose_y_reg, pose_h_reg;
    logic [31:0] new_x_reg;
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    ddo_pkg::mul_req_t  mreq;
    logic [AW-1:0]      ma;
    logic [BW-1:0]      mb;
    logic               mdone;
    logic [AW-1:0]      mprod;
    logic               cstart;
    logic [31:0]        cangle;
    logic               cdone;
    logic signed [33:0] cos_q30, sin_q30;

    logic signed [40:0] wsum, wdif;
    logic signed [40:0] mean_w;
    logic signed [40:0] diff_w;
    logic               s_acc;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // mean travel and wheel difference, rounded to Q16.16
    assign wsum   = $signed({dl_reg[39], dl_reg}) + $signed({mprod[39], mprod[39:0]});
    assign wdif   = $signed({mprod[39], mprod[39:0]}) - $signed({dl_reg[39], dl_reg});
    assign mean_w = (wsum + 41'sd256) >>> 9;
    assign diff_w = (wdif + 41'sd128) >>> 8;

    assign cangle = pose_h_reg + mprod[64:33];

    // sequence and operand select
    always_comb begin
        state_next = state_reg;
        mreq       = '0;
        ma         = '0;
        mb         = '0;
        cstart     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    mreq.start = 1'b1;
                    mreq.len   = LW'(24);
                    ma         = AW'($signed(s_tdata[15:0]));
                    mb         = BW'(lmpt_reg);
                    state_next = S_DL;
                end
            end
            S_DL: begin
                if (mdone) begin
                    mreq.start = 1'b1;
                    mreq.len   = LW'(24);
                    ma         = AW'($signed(tick_r_reg));
                    mb         = BW'(rmpt_reg);
                    state_next = S_DR;
                end
            end
            S_DR: begin
                if (mdone) begin
                    mreq.start = 1'b1;
                    mreq.len   = LW'(24);
                    ma         = AW'($signed(diff_w[32:0]));
                    mb         = BW'(idt_reg);
                    state_next = S_RAD;
                end
            end
            S_RAD: begin
                if (mdone) begin
                    mreq.start = 1'b1;
                    mreq.len   = LW'(30);
                    ma         = mprod;
                    mb         = BW'(ddo_pkg::TURN_PER_RAD_Q32);
                    state_next = S_TURN;
                end
            end
            S_TURN: begin
                if (mdone) begin
                    cstart     = 1'b1;
                    state_next = S_CORD;
                end
            end
            S_CORD: begin
                if (cdone) begin
                    mreq.start    = 1'b1;
                    mreq.b_signed = 1'b1;
                    mreq.len      = LW'(BW);
                    ma            = AW'($signed(mean_reg));
                    mb            = cos_q30;
                    state_next    = S_MX;
                end
            end
            S_MX: begin
                if (mdone) begin
                    mreq.start    = 1'b1;
                    mreq.b_signed = 1'b1;
                    mreq.len      = LW'(BW);
                    ma            = AW'($signed(mean_reg));
                    mb            = sin_q30;
                    state_next    = S_MY;
                end
            end
            S_MY: begin
                if (mdone) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    ddo_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .a_in    (ma),
        .b_in    (mb),
        .done    (mdone),
        .prod    (mprod)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cstart),
        .angle   (cangle),
        .done    (cdone),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // control state, registers and pose
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            lmpt_reg     <= '0;
            rmpt_reg     <= '0;
            idt_reg      <= '0;
            pose_x_reg   <= '0;
            pose_y_reg   <= '0;
            pose_h_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    ddo_pkg::REG_LEFT_MPT:  lmpt_reg <= cfg_data;
                    ddo_pkg::REG_RIGHT_MPT: rmpt_reg <= cfg_data;
                    ddo_pkg::REG_INV_TRACK: idt_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                pose_x_reg   <= new_x_reg;
                pose_y_reg   <= ddo_pkg::sat_add(pose_y_reg, mprod);
                pose_h_reg   <= pose_h_reg + dth_reg;
            end
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tick_r_reg <= s_tdata[31:16];
        end
        if (state_reg == S_DL && mdone) begin
            dl_reg <= mprod[39:0];
        end
        if (state_reg == S_DR && mdone) begin
            mean_reg <= mean_w[31:0];
        end
        if (state_reg == S_TURN && mdone) begin
            dth_reg <= mprod[63:32];
        end
        if (state_reg == S_MX && mdone) begin
            new_x_reg <= ddo_pkg::sat_add(pose_x_reg, mprod);
        end
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {pose_h_reg + dth_reg,
                            ddo_pkg::sat_add(pose_y_reg, mprod),
                            new_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
